[design/cfr_pkg.sv]
`timescale 1ns / 1ps

package cfr_pkg;

    // Default depth of the body store.
    localparam int MAX_RECEIVE_BYTES_DEF = 128;

    // Frame position code that means no frame is in progress.
    localparam logic [7:0] POS_IDLE = 8'hff;

    // Configuration register indexes.
    localparam logic [7:0] REG_STATION_ADDRESS = 8'd0;
    localparam logic [7:0] REG_RECEIVE_LENGTH  = 8'd1;

    // Reset values of the configuration registers.
    localparam logic [7:0] STATION_ADDRESS_RST = 8'd0;
    localparam logic [7:0] RECEIVE_LENGTH_RST  = 8'd16;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SINGLE,
        S_RUN_RD,
        S_RUN_PUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the input word and read the previous body byte
        logic eval;        // update the frame state from the latched word
        logic put_single;  // load a not-done result into the output register
        logic rd_run;      // read the next payload byte of the run
        logic put_run;     // load a payload result into the output register
        logic clr_k;       // clear the run counter
        logic inc_k;       // advance the run counter
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic complete;    // the latched word completes a frame
        logic out_free;    // the output register can take a word this cycle
        logic k_last;      // the run counter is on the final payload byte
    } status_t;

endpackage

[design/complement_frame_receiver_unit.sv]
`timescale 1ns / 1ps

// Complement frame receiver.
// Received serial bytes enter one word at a time on the s_ channel. Frames
// are three bytes rising by 2, the station address and its complement, then
// receive_length body bytes in which every second byte complements the one
// before. Each input word that does not complete a frame yields one not-done
// word on the m_ channel; a completing word yields the even body bytes as a
// run with tuser set and tlast on the final one.
// Registers are written on the cfg channel, which is always ready; write them
// only while no word is in flight.
// Flow: the input word is captured with a read of the previous body byte,
// the frame state is updated, then the not-done word is loaded into the
// output register; a completing word instead reads and loads each payload
// word in turn through the single registered read port of the body store.
// No new input word is taken until the last output word is loaded.
// Reset clears the registers to their defaults, leaves the receiver idle and
// empties the output register. When the m_ side stalls, the output word
// holds and the controller waits before loading the next one; after a
// not-done word or the last run word, one further input word is taken meanwhile.
module complement_frame_receiver_unit
#(
    parameter int MAX_RECEIVE_BYTES = cfr_pkg::MAX_RECEIVE_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] data_byte
    output logic       m_tuser,    // [0] frame_done
    output logic       m_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfr_pkg::cmd_t    cmd;
    cfr_pkg::status_t st;

    assign cfg_ready = 1'b1;

    cfr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    cfr_datapath
    #(
        .MAX_RECEIVE_BYTES (MAX_RECEIVE_BYTES)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .frame_done (m_tuser),
        .data_byte  (m_tdata),
        .last       (m_tlast),
        .cmd        (cmd),
        .st         (st)
    );

endmodule

[design/cfr_ctrl.sv]
`timescale 1ns / 1ps

module cfr_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  cfr_pkg::status_t st,
    output cfr_pkg::cmd_t    cmd
);

    cfr_pkg::state_t state_reg;
    cfr_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfr_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            cfr_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = cfr_pkg::S_EVAL;
                end
            end
            cfr_pkg::S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (st.complete)
                begin
                    cmd.clr_k  = 1'b1;
                    state_next = cfr_pkg::S_RUN_RD;
                end
                else
                begin
                    state_next = cfr_pkg::S_SINGLE;
                end
            end
            cfr_pkg::S_SINGLE:
            begin
                if (st.out_free)
                begin
                    cmd.put_single = 1'b1;
                    state_next     = cfr_pkg::S_IDLE;
                end
            end
            cfr_pkg::S_RUN_RD:
            begin
                cmd.rd_run = 1'b1;
                state_next = cfr_pkg::S_RUN_PUT;
            end
            cfr_pkg::S_RUN_PUT:
            begin
                if (st.out_free)
                begin
                    cmd.put_run = 1'b1;
                    if (st.k_last)
                    begin
                        state_next = cfr_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.inc_k  = 1'b1;
                        state_next = cfr_pkg::S_RUN_RD;
                    end
                end
            end
            default:
            begin
                state_next = cfr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[design/cfr_datapath.sv]
`timescale 1ns / 1ps

module cfr_datapath
#(
    parameter int MAX_RECEIVE_BYTES = cfr_pkg::MAX_RECEIVE_BYTES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       rx_byte,
    input  logic             cfg_valid,
    input  logic [7:0]       cfg_index,
    input  logic [7:0]       cfg_data,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic             frame_done,
    output logic [7:0]       data_byte,
    output logic             last,
    input  cfr_pkg::cmd_t    cmd,
    output cfr_pkg::status_t st
);

    localparam int         AW      = $clog2(MAX_RECEIVE_BYTES);
    localparam logic [7:0] MAX_LEN = 8'(MAX_RECEIVE_BYTES);

    // Configuration registers.
    logic [7:0] station_reg;
    logic [7:0] length_reg;

    // Frame state.
    logic [7:0] prev2_reg;
    logic [7:0] prev1_reg;
    logic [7:0] pos_reg;
    logic [7:0] pos_next;
    logic [7:0] addr_seen_reg;
    logic [7:0] addr_seen_next;
    logic [7:0] byte_reg;

    // Body store and its registered read port.
    logic [7:0]    mem [0:MAX_RECEIVE_BYTES-1];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    // Run counter and output register.
    logic [AW-1:0] k_reg;
    logic          out_valid_reg;
    logic          out_done_reg;
    logic [7:0]    out_data_reg;
    logic          out_last_reg;

    logic [7:0] len_eff;
    logic [8:0] len_p2;
    logic [7:0] count;
    logic [7:0] pos_a;
    logic [7:0] pos_b;
    logic [7:0] pos_c;
    logic [7:0] body_idx;
    logic       in_body;
    logic       start_seen;
    logic       complete;

    // Clamp the programmed length to the range from one to the store depth.
    always_comb
    begin
        if (length_reg == 8'd0)
        begin
            len_eff = 8'd1;
        end
        else if (length_reg > MAX_LEN)
        begin
            len_eff = MAX_LEN;
        end
        else
        begin
            len_eff = length_reg;
        end
        len_p2 = {1'b0, len_eff} + 9'd2;
        count  = 8'(({1'b0, len_eff} + 9'd1) >> 1);
    end

    // Frame state update for the latched word.
    always_comb
    begin
        addr_seen_next = addr_seen_reg;
        pos_a          = pos_reg;
        if (pos_reg == 8'd1)
        begin
            addr_seen_next = byte_reg;
        end
        else if (pos_reg == 8'd2)
        begin
            if ((addr_seen_reg != station_reg) || (addr_seen_reg != ~byte_reg))
            begin
                pos_a = cfr_pkg::POS_IDLE;
            end
        end

        in_body  = ({1'b0, pos_a} >= 9'd3) && ({1'b0, pos_a} <= len_p2);
        body_idx = pos_a - 8'd3;
        pos_b    = pos_a;
        // Odd body bytes must complement the byte stored just before.
        if (in_body && !pos_a[0] && (byte_reg != ~rd_data_reg))
        begin
            pos_b = cfr_pkg::POS_IDLE;
        end

        complete   = ({1'b0, pos_b} == len_p2);
        start_seen = ((prev2_reg + 8'd2) == prev1_reg) && ((prev1_reg + 8'd2) == byte_reg);
        pos_c      = start_seen ? 8'd0 : pos_b;
        if (complete || (pos_c == cfr_pkg::POS_IDLE))
        begin
            pos_next = cfr_pkg::POS_IDLE;
        end
        else
        begin
            pos_next = pos_c + 8'd1;
        end
    end

    assign wr_en   = cmd.eval && in_body;
    assign wr_addr = body_idx[AW-1:0];

    // Read address: the previous body byte on capture, a payload byte in a run.
    always_comb
    begin
        logic [7:0] prev_idx;
        logic [7:0] run_idx;
        prev_idx = pos_reg - 8'd4;
        run_idx  = 8'(k_reg) << 1;
        rd_addr  = cmd.rd_run ? run_idx[AW-1:0] : prev_idx[AW-1:0];
    end

    // Body store.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= byte_reg;
        end
        if (cmd.capture || cmd.rd_run)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Input word latch.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= rx_byte;
        end
    end

    // Configuration and frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg   <= cfr_pkg::STATION_ADDRESS_RST;
            length_reg    <= cfr_pkg::RECEIVE_LENGTH_RST;
            prev2_reg     <= 8'd0;
            prev1_reg     <= 8'd0;
            pos_reg       <= cfr_pkg::POS_IDLE;
            addr_seen_reg <= 8'd0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == cfr_pkg::REG_STATION_ADDRESS))
            begin
                station_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == cfr_pkg::REG_RECEIVE_LENGTH))
            begin
                length_reg <= cfg_data;
            end
            if (cmd.eval)
            begin
                prev2_reg     <= prev1_reg;
                prev1_reg     <= byte_reg;
                pos_reg       <= pos_next;
                addr_seen_reg <= addr_seen_next;
            end
        end
    end

    // Run counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else if (cmd.clr_k)
        begin
            k_reg <= '0;
        end
        else if (cmd.inc_k)
        begin
            k_reg <= k_reg + AW'(1);
        end
    end

    // Output register: loaded when free, emptied when the word is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.put_single || cmd.put_run)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.put_single)
        begin
            out_done_reg <= 1'b0;
            out_data_reg <= 8'd0;
            out_last_reg <= 1'b1;
        end
        else if (cmd.put_run)
        begin
            out_done_reg <= 1'b1;
            out_data_reg <= rd_data_reg;
            out_last_reg <= st.k_last;
        end
    end

    assign st.complete = complete;
    assign st.out_free = !out_valid_reg || m_tready;
    assign st.k_last   = (8'(k_reg) == (count - 8'd1));

    assign m_tvalid   = out_valid_reg;
    assign frame_done = out_done_reg;
    assign data_byte  = out_data_reg;
    assign last       = out_last_reg;

    // A word is never loaded over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.put_single || cmd.put_run) |-> (!out_valid_reg || m_tready))
        else $error("output word overwritten while stalled");

    // A completed frame always returns the receiver to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.eval && complete) |=> (pos_reg == cfr_pkg::POS_IDLE))
        else $error("frame position not idle after completion");

    // Position zero is only transient; it never reaches the register.
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != 8'd0)
        else $error("frame position register holds zero");

    // A stalled payload word keeps its frame-done flag set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready && out_done_reg) |=> out_done_reg)
        else $error("payload word changed while stalled");

endmodule
